// File: sv/cartesian_to_cylindrical_vector_top_defines.svh
// Assertion macros shared by the cartesian-to-cylindrical RTL.
`ifndef CARTESIAN_TO_CYLINDRICAL_VECTOR_TOP_DEFINES_SVH
`define CARTESIAN_TO_CYLINDRICAL_VECTOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define C2CV_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define C2CV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/c2cv_pkg.sv
// Shared widths, constants and the pipeline stage type of the cylindrical converter.
package c2cv_pkg;

	localparam int DATA_WIDTH   = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int GUARD_BITS   = 8;

	// Coordinate path: pre-rotation and CORDIC growth need two bits, one more for margin.
	localparam int CW = DATA_WIDTH + 3;
	// Field path: guard bits plus growth of sqrt(2) * 1.647.
	localparam int BW = DATA_WIDTH + GUARD_BITS + 3;
	// Inverse CORDIC gain in Q22, signed width.
	localparam int GW = 23;
	localparam int PW = BW + GW;
	localparam int OW = DATA_WIDTH + 1;
	localparam int SHW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	localparam logic signed [GW-1:0] INV_GAIN_Q22 = GW'(2547003);
	// Scale of a gain-corrected product, and its rounding bias.
	localparam int PROD_SHIFT = GUARD_BITS + 22;
	localparam logic signed [PW-1:0] ROUND_BIAS = PW'(1) <<< (PROD_SHIFT - 1);

	localparam int IN_BITS  = 5 * DATA_WIDTH;
	localparam int IN_TW    = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = 2 * OW + DATA_WIDTH;
	localparam int OUT_TW   = ((OUT_BITS + 7) / 8) * 8;

	typedef struct packed {
		logic                         valid;
		logic                         origin;
		logic signed [CW-1:0]         cx;
		logic signed [CW-1:0]         cy;
		logic signed [BW-1:0]         b1;
		logic signed [BW-1:0]         b2;
		logic signed [DATA_WIDTH-1:0] b3;
	} stage_t;

endpackage

// File: sv/cartesian_to_cylindrical_vector_top.sv
// Top level: pipelined CORDIC converter of field vectors to cylindrical components.
//
//  channel  | group  | dir | content (lowest bits first)
//  ---------+--------+-----+---------------------------------------------------------
//  input    | s_axis | in  | coord_x 16, coord_y 16, field_x 16, field_y 16, field_z 16
//  output   | m_axis | out | field_radial 17, field_azimuthal 17, field_axial 16, 6 zeros
//
//  One transfer per cycle in and out while the output is not stalled. Data passes
//  through an input register with the 180-degree pre-rotation, one register per
//  micro-rotation, the gain multiplier register and the rounding/output register.
//  Reset (arst_n low) clears all valid bits at once; payload registers are not reset.
//  The whole pipeline holds while a result waits at the output and m_axis_tready is low;
//  s_axis_tready is low for exactly those cycles.
`include "cartesian_to_cylindrical_vector_top_defines.svh"

module cartesian_to_cylindrical_vector_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// coord_x, coord_y, field_x, field_y, field_z
	input  logic [c2cv_pkg::IN_TW-1:0]    s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// field_radial, field_azimuthal, field_axial, zero fill
	output logic [c2cv_pkg::OUT_TW-1:0]   m_axis_tdata
);
	import c2cv_pkg::*;

	typedef struct packed {
		logic                         valid;
		logic signed [PW-1:0]         p1;
		logic signed [PW-1:0]         p2;
		logic signed [DATA_WIDTH-1:0] b3;
	} mul_t;

	typedef struct packed {
		logic                         valid;
		logic signed [OW-1:0]         rad;
		logic signed [OW-1:0]         azi;
		logic signed [DATA_WIDTH-1:0] axial;
	} out_t;

	logic                         en;
	logic signed [DATA_WIDTH-1:0] in_x, in_y, in_b1, in_b2, in_b3;
	logic signed [BW-1:0]         sc_b1, sc_b2;
	logic                         neg;
	stage_t                       pre_nxt;
	stage_t                       pre_s1;
	stage_t                       crd_s [CORDIC_STEPS];
	stage_t                       last;
	logic signed [PW-1:0]         prod1, prod2;
	mul_t                         mul_s;
	logic signed [PW-1:0]         r1, r2;
	out_t                         out_s;

	// Global advance: move unless a result is stuck at the output
	assign en            = !out_s.valid || m_axis_tready;
	assign s_axis_tready = en;

	assign in_x  = s_axis_tdata[0*DATA_WIDTH +: DATA_WIDTH];
	assign in_y  = s_axis_tdata[1*DATA_WIDTH +: DATA_WIDTH];
	assign in_b1 = s_axis_tdata[2*DATA_WIDTH +: DATA_WIDTH];
	assign in_b2 = s_axis_tdata[3*DATA_WIDTH +: DATA_WIDTH];
	assign in_b3 = s_axis_tdata[4*DATA_WIDTH +: DATA_WIDTH];

	// Add guard bits and pre-rotate by 180 degrees for negative x
	assign sc_b1 = BW'(in_b1) <<< GUARD_BITS;
	assign sc_b2 = BW'(in_b2) <<< GUARD_BITS;
	assign neg   = in_x[DATA_WIDTH-1];

	always_comb begin
		pre_nxt.valid  = s_axis_tvalid;
		pre_nxt.origin = (in_x == '0) && (in_y == '0);
		pre_nxt.cx     = neg ? -CW'(in_x) : CW'(in_x);
		pre_nxt.cy     = neg ? -CW'(in_y) : CW'(in_y);
		pre_nxt.b1     = neg ? -sc_b1 : sc_b1;
		pre_nxt.b2     = neg ? -sc_b2 : sc_b2;
		pre_nxt.b3     = in_b3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_s1.valid <= 1'b0;
		end else if (en) begin
			pre_s1 <= pre_nxt;
		end
	end

	// Micro-rotation chain, one register per step
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_crd
		if (i == 0) begin : g_first
			c2cv_stage u_stage (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (en),
				.shift  (SHW'(i)),
				.d      (pre_s1),
				.q      (crd_s[i])
			);
		end else begin : g_next
			c2cv_stage u_stage (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (en),
				.shift  (SHW'(i)),
				.d      (crd_s[i-1]),
				.q      (crd_s[i])
			);
		end
	end

	assign last = crd_s[CORDIC_STEPS-1];

	// Gain correction; the origin point is only moved to the product scale
	assign prod1 = last.origin ? (PW'(last.b1) <<< 22) : PW'(last.b1) * PW'(INV_GAIN_Q22);
	assign prod2 = last.origin ? (PW'(last.b2) <<< 22) : PW'(last.b2) * PW'(INV_GAIN_Q22);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_s.valid <= 1'b0;
		end else if (en) begin
			mul_s.valid <= last.valid;
			mul_s.p1    <= prod1;
			mul_s.p2    <= prod2;
			mul_s.b3    <= last.b3;
		end
	end

	// Round to nearest, ties upward, and register the result
	assign r1 = mul_s.p1 + ROUND_BIAS;
	assign r2 = mul_s.p2 + ROUND_BIAS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_s.valid <= 1'b0;
		end else if (en) begin
			out_s.valid <= mul_s.valid;
			out_s.rad   <= r1[PROD_SHIFT +: OW];
			out_s.azi   <= r2[PROD_SHIFT +: OW];
			out_s.axial <= mul_s.b3;
		end
	end

	assign m_axis_tvalid = out_s.valid;
	assign m_axis_tdata  = OUT_TW'({out_s.axial, out_s.azi, out_s.rad});

	// Checks on pipeline control
	`C2CV_ASSERT_NEXT(a_accept_loads, s_axis_tvalid && s_axis_tready, pre_s1.valid, "accepted transfer missing from first stage")
	`C2CV_ASSERT_NEXT(a_stall_holds, !s_axis_tready, $stable(pre_s1) && $stable(mul_s), "pipeline moved during stall")
	`C2CV_ASSERT_NEXT(a_axial_follows, en && mul_s.valid, m_axis_tvalid && (out_s.axial == $past(mul_s.b3)), "axial field lost at output")

endmodule

// File: sv/c2cv_stage.sv
// One registered CORDIC micro-rotation on the coordinate pair and the field pair.
module c2cv_stage (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [c2cv_pkg::SHW-1:0]  shift,
	input  c2cv_pkg::stage_t          d,
	output c2cv_pkg::stage_t          q
);
	import c2cv_pkg::*;

	logic signed [CW-1:0] xs, ys;
	logic signed [BW-1:0] b1s, b2s;
	stage_t               nxt;

	assign xs  = d.cx >>> shift;
	assign ys  = d.cy >>> shift;
	assign b1s = d.b1 >>> shift;
	assign b2s = d.b2 >>> shift;

	// Rotate toward the positive x axis; the field follows with the same sign
	always_comb begin
		nxt = d;
		if (!d.cy[CW-1]) begin
			nxt.cx = d.cx + ys;
			nxt.cy = d.cy - xs;
			nxt.b1 = d.b1 + b2s;
			nxt.b2 = d.b2 - b1s;
		end else begin
			nxt.cx = d.cx - ys;
			nxt.cy = d.cy + xs;
			nxt.b1 = d.b1 - b2s;
			nxt.b2 = d.b2 + b1s;
		end
		// Hold the field at the origin point
		if (d.origin) begin
			nxt.b1 = d.b1;
			nxt.b2 = d.b2;
		end
	end

	// Advance on enable
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q.valid <= 1'b0;
		end else if (en) begin
			q <= nxt;
		end
	end

endmodule
